// ----- rtl/core/msp_pkg.sv -----
// Shared types, constants and codes of the multipath subflow picker.
package msp_pkg;

  // Default table depth and deroute period.
  localparam int MAX_SUBFLOWS_DEF   = 8;
  localparam int DEROUTE_PERIOD_DEF = 10;

  // Field widths fixed by the item format.
  localparam int SLOT_W   = 3;
  localparam int PATH_W   = 6;
  localparam int STATUS_W = 10;
  localparam int SEQ_W    = 32;
  localparam int RTT_W    = 32;
  localparam int MASK_W   = 32;
  localparam int ESTAB_W  = 4;
  localparam int DCNT_W   = 4;
  // Only slots reachable by the 3-bit slot field can ever be present, so
  // counts of present entries never exceed eight.
  localparam int PCNT_W   = 4;

  localparam logic [RTT_W-1:0] RTT_NONE = 32'hffff_ffff;

  // Status bit positions.
  localparam int ST_PRESENT  = 0;
  localparam int ST_CAN_SEND = 1;
  localparam int ST_PRE_EST  = 2;
  localparam int ST_FAILED   = 3;
  localparam int ST_LOSS     = 4;
  localparam int ST_RENO     = 5;
  localparam int ST_UNA_HIGH = 6;
  localparam int ST_FULLY    = 7;
  localparam int ST_SECOND   = 8;
  localparam int ST_LOW_PRIO = 9;

  // Configuration port.
  localparam int APB_ADDR_W = 2;
  localparam int APB_DATA_W = 32;
  localparam logic [APB_ADDR_W-1:0] REG_DATA_FIN_PATH = 2'd0;
  localparam logic [PATH_W-1:0]     DATA_FIN_PATH_RST = 6'd1;

  // Operation codes.
  typedef enum logic {
    OP_UPDATE   = 1'b0,
    OP_SCHEDULE = 1'b1
  } op_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE
  } state_t;

  // One subflow table entry as stored in memory.
  typedef struct packed {
    logic [SEQ_W-1:0]    end_seq;
    logic [RTT_W-1:0]    rtt;
    logic [PATH_W-1:0]   path;
    logic [STATUS_W-1:0] status;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Request context held for the duration of a schedule transaction.
  typedef struct packed {
    logic               has_packet;
    logic [SEQ_W-1:0]   packet_seq;
    logic [MASK_W-1:0]  packet_path_mask;
    logic               is_data_fin;
    logic               receive_shut;
    logic [ESTAB_W-1:0] established_count;
  } req_ctx_t;

  // Summary produced by the table scan.
  typedef struct packed {
    logic [PCNT_W-1:0] count;
    logic              first_ok;
    logic [SLOT_W-1:0] first_slot;
    logic              df_found;
    logic [SLOT_W-1:0] df_slot;
    logic              has_best;
    logic [SLOT_W-1:0] best;
    logic              has_low;
    logic [SLOT_W-1:0] low;
    logic              has_back;
    logic [SLOT_W-1:0] back;
    logic [PCNT_W-1:0] backups;
  } scan_res_t;

endpackage

// ----- rtl/core/msp_req_if.sv -----
// Request channel interface of the multipath subflow picker.
interface msp_req_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [2:0]  slot;
  logic [31:0] rtt_value;
  logic [9:0]  status_bits;
  logic [5:0]  path_number;
  logic [31:0] expected_seq;
  logic        has_packet;
  logic [31:0] packet_seq;
  logic [31:0] packet_path_mask;
  logic        is_data_fin;
  logic        receive_shut;
  logic [3:0]  established_count;

  modport source (
    output valid, operation, slot, rtt_value, status_bits, path_number, expected_seq,
           has_packet, packet_seq, packet_path_mask, is_data_fin, receive_shut,
           established_count,
    input  ready
  );

  modport sink (
    input  valid, operation, slot, rtt_value, status_bits, path_number, expected_seq,
           has_packet, packet_seq, packet_path_mask, is_data_fin, receive_shut,
           established_count,
    output ready
  );
endinterface

// ----- rtl/core/msp_res_if.sv -----
// Result channel interface of the multipath subflow picker.
interface msp_res_if;
  logic       valid;
  logic       ready;
  logic       found;
  logic [2:0] chosen_slot;
  logic       clear_mask;

  modport source (
    output valid, found, chosen_slot, clear_mask,
    input  ready
  );

  modport sink (
    input  valid, found, chosen_slot, clear_mask,
    output ready
  );
endinterface

// ----- rtl/core/msp_ram.sv -----
// Generic single-port RAM with registered read data.
module msp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write on request; read data is registered every cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- rtl/core/msp_apb_regs.sv -----
// Configuration register block behind the APB-style port.
module msp_apb_regs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [msp_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [msp_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [msp_pkg::APB_DATA_W-1:0]     prdata,
  output logic                               pready,
  output logic [msp_pkg::PATH_W-1:0]         data_fin_path
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // Data-fin path register.
  always_ff @(posedge clk) begin
    if (rst) begin
      data_fin_path <= msp_pkg::DATA_FIN_PATH_RST;
    end else if (wr_en && paddr == msp_pkg::REG_DATA_FIN_PATH) begin
      data_fin_path <= pwdata[msp_pkg::PATH_W-1:0];
    end
  end

  // Read-back mux.
  always_comb begin
    prdata = '0;
    if (paddr == msp_pkg::REG_DATA_FIN_PATH) begin
      prdata = msp_pkg::APB_DATA_W'(data_fin_path);
    end
  end

endmodule

// ----- rtl/core/msp_scan.sv -----
// Table scan unit: folds one subflow entry per cycle, while enabled, into the scan summary.
module msp_scan (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          en,
  input  logic [msp_pkg::SLOT_W-1:0]    slot_idx,
  input  logic                          entry_ok,
  input  msp_pkg::entry_t               entry,
  input  msp_pkg::req_ctx_t             ctx,
  input  logic [msp_pkg::PATH_W-1:0]    data_fin_path,
  output msp_pkg::scan_res_t            res
);

  msp_pkg::scan_res_t          acc;
  msp_pkg::scan_res_t          acc_next;
  logic [msp_pkg::RTT_W-1:0]   best_rtt;
  logic [msp_pkg::RTT_W-1:0]   best_rtt_next;
  logic [msp_pkg::RTT_W-1:0]   low_rtt;
  logic [msp_pkg::RTT_W-1:0]   low_rtt_next;
  logic [msp_pkg::STATUS_W-1:0] st;
  logic                        present;
  logic                        lp_entry;
  logic                        usable;
  logic                        queued;
  logic                        considered;
  logic [msp_pkg::PATH_W-1:0]  path_m1;

  // An entry whose valid bit is clear reads as not present.
  assign st       = entry_ok ? entry.status : '0;
  assign present  = st[msp_pkg::ST_PRESENT];
  assign lp_entry = st[msp_pkg::ST_LOW_PRIO];

  // Availability test of the current entry.
  always_comb begin
    usable = st[msp_pkg::ST_PRESENT] && st[msp_pkg::ST_CAN_SEND] &&
             !st[msp_pkg::ST_PRE_EST] && !st[msp_pkg::ST_FAILED];
    if (st[msp_pkg::ST_LOSS] && !(st[msp_pkg::ST_RENO] && st[msp_pkg::ST_UNA_HIGH])) begin
      usable = 1'b0;
    end
    if (!st[msp_pkg::ST_FULLY] && ctx.has_packet && st[msp_pkg::ST_SECOND] &&
        entry.end_seq != ctx.packet_seq) begin
      usable = 1'b0;
    end
  end

  // Already queued on this path; paths outside 1..32 have no flag.
  assign path_m1 = entry.path - 6'd1;
  assign queued  = ctx.has_packet && entry.path != '0 && entry.path <= 6'd32 &&
                   ctx.packet_path_mask[path_m1[4:0]];

  assign considered = lp_entry ? (entry.rtt < low_rtt) : (entry.rtt < best_rtt);

  // Fold the entry into the running summary.
  always_comb begin
    acc_next      = acc;
    best_rtt_next = best_rtt;
    low_rtt_next  = low_rtt;
    if (en && present) begin
      acc_next.count = acc.count + 1'b1;
      if (acc.count == '0) begin
        acc_next.first_ok   = usable;
        acc_next.first_slot = slot_idx;
      end
      if (!acc.df_found && entry.path == data_fin_path && usable) begin
        acc_next.df_found = 1'b1;
        acc_next.df_slot  = slot_idx;
      end
      if (lp_entry) begin
        acc_next.backups = acc.backups + 1'b1;
      end
      if (considered && usable) begin
        if (queued) begin
          acc_next.has_back = 1'b1;
          acc_next.back     = slot_idx;
        end else if (lp_entry) begin
          acc_next.has_low = 1'b1;
          acc_next.low     = slot_idx;
          low_rtt_next     = entry.rtt;
        end else begin
          acc_next.has_best = 1'b1;
          acc_next.best     = slot_idx;
          best_rtt_next     = entry.rtt;
        end
      end
    end
  end

  // Summary registers, cleared at the start of each schedule transaction.
  always_ff @(posedge clk) begin
    if (rst || start) begin
      acc      <= '0;
      best_rtt <= msp_pkg::RTT_NONE;
      low_rtt  <= msp_pkg::RTT_NONE;
    end else begin
      acc      <= acc_next;
      best_rtt <= best_rtt_next;
      low_rtt  <= low_rtt_next;
    end
  end

  assign res = acc;

endmodule

// ----- rtl/core/multipath_subflow_picker_unit.sv -----
// Top level of the multipath subflow picker: table memory, sequencer and decision.
// Update transaction: written to memory at the accepting edge, no result.
// Schedule transaction: the table memory is read one entry per cycle, each read word is folded into
// the scan summary, the decision is registered once the output register is free, and the next
// request is taken only after the sequencer has returned to idle.
// Synchronous reset clears all entry valid bits, the deroute counter and data_fin_path to 1.
module multipath_subflow_picker_unit #(
  parameter int MAX_SUBFLOWS   = msp_pkg::MAX_SUBFLOWS_DEF,
  parameter int DEROUTE_PERIOD = msp_pkg::DEROUTE_PERIOD_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  msp_req_if.sink                        req,
  msp_res_if.source                      res,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [msp_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [msp_pkg::APB_DATA_W-1:0] pwdata,
  output logic [msp_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);

  localparam int IDX_W = $clog2(MAX_SUBFLOWS);
  localparam int CNT_W = $clog2(MAX_SUBFLOWS + 1);

  msp_pkg::state_t             state;
  msp_pkg::state_t             state_next;
  logic [CNT_W-1:0]            rd_cnt;
  logic                        rd_pending;
  logic [IDX_W-1:0]            rd_idx;
  logic [MAX_SUBFLOWS-1:0]     valid;
  logic [msp_pkg::DCNT_W-1:0]  deroute_count;
  logic [msp_pkg::DCNT_W:0]    deroute_inc;
  msp_pkg::req_ctx_t           ctx;
  logic [msp_pkg::PATH_W-1:0]  data_fin_path;

  logic                        accept;
  logic                        upd_we;
  logic                        scan_start;
  logic                        rd_issue;
  logic                        scan_done;
  logic                        out_free;
  logic                        dec_load;
  logic [IDX_W-1:0]            ram_addr;
  msp_pkg::entry_t             wr_entry;
  logic [msp_pkg::ENTRY_W-1:0] rd_word;
  msp_pkg::entry_t             rd_entry;
  msp_pkg::scan_res_t          scan_res;

  logic                        dec_found;
  logic [msp_pkg::SLOT_W-1:0]  dec_slot;
  logic                        dec_clear;
  logic                        dec_advance;

  logic                        res_valid;
  logic                        res_found;
  logic [msp_pkg::SLOT_W-1:0]  res_slot;
  logic                        res_clear;

  // Configuration registers.
  msp_apb_regs u_regs (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .data_fin_path (data_fin_path)
  );

  // Request handshake and update write.
  assign req.ready  = (state == msp_pkg::ST_IDLE);
  assign accept     = req.valid && req.ready;
  assign upd_we     = accept && (req.operation == msp_pkg::OP_UPDATE) &&
                      (32'(req.slot) < MAX_SUBFLOWS);
  assign scan_start = accept && (req.operation == msp_pkg::OP_SCHEDULE);

  assign wr_entry.end_seq = req.expected_seq;
  assign wr_entry.rtt     = req.rtt_value;
  assign wr_entry.path    = req.path_number;
  assign wr_entry.status  = req.status_bits;

  // The port writes in idle and reads one entry per cycle while scanning.
  assign rd_issue  = (state == msp_pkg::ST_SCAN) && (32'(rd_cnt) < MAX_SUBFLOWS);
  assign scan_done = (state == msp_pkg::ST_SCAN) && !rd_issue && rd_pending;
  assign ram_addr  = (state == msp_pkg::ST_IDLE) ? IDX_W'(req.slot) : rd_cnt[IDX_W-1:0];

  msp_ram #(
    .WIDTH (msp_pkg::ENTRY_W),
    .DEPTH (MAX_SUBFLOWS)
  ) u_table (
    .clk   (clk),
    .we    (upd_we),
    .addr  (ram_addr),
    .wdata (wr_entry),
    .rdata (rd_word)
  );

  assign rd_entry = rd_word;

  // Per-entry valid bits; an entry never written reads as not present.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (upd_we) begin
      valid[IDX_W'(req.slot)] <= 1'b1;
    end
  end

  // Read sequencing.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_cnt     <= '0;
      rd_pending <= 1'b0;
    end else begin
      rd_pending <= rd_issue;
      if (scan_start) begin
        rd_cnt <= '0;
      end else if (rd_issue) begin
        rd_cnt <= rd_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= rd_cnt[IDX_W-1:0];
  end

  // Request context held for the scan.
  always_ff @(posedge clk) begin
    if (scan_start) begin
      ctx.has_packet        <= req.has_packet;
      ctx.packet_seq        <= req.packet_seq;
      ctx.packet_path_mask  <= req.packet_path_mask;
      ctx.is_data_fin       <= req.is_data_fin;
      ctx.receive_shut      <= req.receive_shut;
      ctx.established_count <= req.established_count;
    end
  end

  msp_scan u_scan (
    .clk           (clk),
    .rst           (rst),
    .start         (scan_start),
    .en            (rd_pending),
    .slot_idx      (msp_pkg::SLOT_W'(rd_idx)),
    .entry_ok      (valid[rd_idx]),
    .entry         (rd_entry),
    .ctx           (ctx),
    .data_fin_path (data_fin_path),
    .res           (scan_res)
  );

  // Decision over the scan summary.
  always_comb begin
    dec_found   = 1'b0;
    dec_slot    = '0;
    dec_clear   = 1'b0;
    dec_advance = 1'b0;
    if (scan_res.count == 4'd1) begin
      // Single present entry.
      if (scan_res.first_ok) begin
        dec_found = 1'b1;
        dec_slot  = scan_res.first_slot;
      end
    end else if (ctx.receive_shut && ctx.has_packet && ctx.is_data_fin &&
                 scan_res.df_found) begin
      // Data fin answered on its configured path.
      dec_found = 1'b1;
      dec_slot  = scan_res.df_slot;
    end else begin
      dec_advance = 1'b1;
      dec_clear   = !((ctx.established_count == scan_res.backups) && scan_res.has_low) &&
                    !scan_res.has_best && scan_res.has_back && ctx.has_packet;
      if (deroute_count != '0) begin
        if (scan_res.has_best) begin
          dec_found = 1'b1;
          dec_slot  = scan_res.best;
        end
      end else if (scan_res.has_low) begin
        dec_found = 1'b1;
        dec_slot  = scan_res.low;
      end else if (scan_res.has_back) begin
        dec_found = 1'b1;
        dec_slot  = scan_res.back;
      end
    end
  end

  assign out_free    = !res_valid || res.ready;
  assign dec_load    = (state == msp_pkg::ST_DECIDE) && out_free;
  assign deroute_inc = {1'b0, deroute_count} + 1'b1;

  // Deroute counter, wrapping at the period.
  always_ff @(posedge clk) begin
    if (rst) begin
      deroute_count <= '0;
    end else if (dec_load && dec_advance) begin
      if (32'(deroute_inc) >= DEROUTE_PERIOD) begin
        deroute_count <= '0;
      end else begin
        deroute_count <= deroute_inc[msp_pkg::DCNT_W-1:0];
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (dec_load) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (dec_load) begin
      res_found <= dec_found;
      res_slot  <= dec_slot;
      res_clear <= dec_clear;
    end
  end

  assign res.valid       = res_valid;
  assign res.found       = res_found;
  assign res.chosen_slot = res_slot;
  assign res.clear_mask  = res_clear;

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= msp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer next state.
  always_comb begin
    state_next = state;
    case (state)
      msp_pkg::ST_IDLE: begin
        if (scan_start) begin
          state_next = msp_pkg::ST_SCAN;
        end
      end
      msp_pkg::ST_SCAN: begin
        if (scan_done) begin
          state_next = msp_pkg::ST_DECIDE;
        end
      end
      msp_pkg::ST_DECIDE: begin
        if (out_free) begin
          state_next = msp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = msp_pkg::ST_IDLE;
      end
    endcase
  end

  // Memory read data is only consumed while scanning.
  a_pending_in_scan: assert property (@(posedge clk) disable iff (rst)
    rd_pending |-> (state == msp_pkg::ST_SCAN))
    else $error("table read data arrived outside the scan");

  // The deroute counter stays inside its period.
  a_deroute_range: assert property (@(posedge clk) disable iff (rst)
    32'(deroute_count) < DEROUTE_PERIOD)
    else $error("deroute counter out of range");

  // A finished decision always lands in the output register.
  a_decide_loads: assert property (@(posedge clk) disable iff (rst)
    dec_load |=> res_valid)
    else $error("decision was not presented");

  // No entry chosen means the slot reads as zero.
  a_slot_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_found) |-> (res_slot == '0))
    else $error("slot nonzero without a chosen entry");

  // An update transaction never moves the deroute counter.
  a_update_keeps_count: assert property (@(posedge clk) disable iff (rst)
    (accept && req.operation == msp_pkg::OP_UPDATE) |=> $stable(deroute_count))
    else $error("update changed the deroute counter");

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench of the multipath subflow picker unit.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD      = 12;
  localparam int RESET_CYCLES    = 5;
  localparam int RANDOM_ITEMS    = 1800;
  localparam int RANDOM_PHASES   = 8;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int SETTLE_CYCLES   = msp_pkg::MAX_SUBFLOWS_DEF + 6;
  localparam int MAX_PRINTS      = 40;
  localparam int N_SLOTS         = msp_pkg::MAX_SUBFLOWS_DEF;

  // Status flags as masks, built from the package bit positions.
  localparam logic [msp_pkg::STATUS_W-1:0] F_PRESENT  =
    msp_pkg::STATUS_W'(1 << msp_pkg::ST_PRESENT);
  localparam logic [msp_pkg::STATUS_W-1:0] F_CAN_SEND =
    msp_pkg::STATUS_W'(1 << msp_pkg::ST_CAN_SEND);
  localparam logic [msp_pkg::STATUS_W-1:0] F_PRE_EST  =
    msp_pkg::STATUS_W'(1 << msp_pkg::ST_PRE_EST);
  localparam logic [msp_pkg::STATUS_W-1:0] F_FAILED   =
    msp_pkg::STATUS_W'(1 << msp_pkg::ST_FAILED);
  localparam logic [msp_pkg::STATUS_W-1:0] F_LOSS     =
    msp_pkg::STATUS_W'(1 << msp_pkg::ST_LOSS);
  localparam logic [msp_pkg::STATUS_W-1:0] F_RENO     =
    msp_pkg::STATUS_W'(1 << msp_pkg::ST_RENO);
  localparam logic [msp_pkg::STATUS_W-1:0] F_UNA_HIGH =
    msp_pkg::STATUS_W'(1 << msp_pkg::ST_UNA_HIGH);
  localparam logic [msp_pkg::STATUS_W-1:0] F_FULLY    =
    msp_pkg::STATUS_W'(1 << msp_pkg::ST_FULLY);
  localparam logic [msp_pkg::STATUS_W-1:0] F_SECOND   =
    msp_pkg::STATUS_W'(1 << msp_pkg::ST_SECOND);
  localparam logic [msp_pkg::STATUS_W-1:0] F_LOW_PRIO =
    msp_pkg::STATUS_W'(1 << msp_pkg::ST_LOW_PRIO);
  localparam logic [msp_pkg::STATUS_W-1:0] F_GOOD     = F_PRESENT | F_CAN_SEND | F_FULLY;

  typedef struct packed {
    msp_pkg::op_t                op;
    logic [msp_pkg::SLOT_W-1:0]  slot;
    logic [msp_pkg::RTT_W-1:0]   rtt;
    logic [msp_pkg::STATUS_W-1:0] status;
    logic [msp_pkg::PATH_W-1:0]  path;
    logic [msp_pkg::SEQ_W-1:0]   end_seq;
    logic                        has_pkt;
    logic [msp_pkg::SEQ_W-1:0]   pkt_seq;
    logic [msp_pkg::MASK_W-1:0]  pkt_mask;
    logic                        fin;
    logic                        rcv_shut;
    logic [msp_pkg::ESTAB_W-1:0] estab;
  } pick_req_t;

  typedef struct packed {
    logic                       found;
    logic [msp_pkg::SLOT_W-1:0] slot;
    logic                       clear;
  } pick_res_t;

  typedef struct {
    pick_req_t req;
    bit        typed;
    pick_res_t res;
  } stim_row_t;

  logic                           clk = 1'b0;
  logic                           rst;
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [msp_pkg::APB_ADDR_W-1:0] paddr;
  logic [msp_pkg::APB_DATA_W-1:0] pwdata;
  logic [msp_pkg::APB_DATA_W-1:0] prdata;
  logic                           pready;

  msp_req_if req_ch ();
  msp_res_if res_ch ();

  multipath_subflow_picker_unit i_dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .res     (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow copy of the subflow table, the deroute counter and the register.
  logic [msp_pkg::RTT_W-1:0]    tbl_rtt     [N_SLOTS];
  logic [msp_pkg::STATUS_W-1:0] tbl_status  [N_SLOTS];
  logic [msp_pkg::PATH_W-1:0]   tbl_path    [N_SLOTS];
  logic [msp_pkg::SEQ_W-1:0]    tbl_end_seq [N_SLOTS];
  int                           deroute_cnt;
  logic [msp_pkg::PATH_W-1:0]   fin_path_cfg;

  pick_res_t expected_picks[$];
  stim_row_t stim_rows[$];

  int send_idle_pct;
  int recv_stall_pct;
  int hold_off_asked;
  int hold_off_seen;
  int hold_off_left;

  int items_sent;
  int updates_sent;
  int schedules_sent;
  int results_checked = 0;
  int found_seen      = 0;
  int clear_seen      = 0;
  int cfg_writes;
  int mismatch_count  = 0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Prints one line per mismatch, up to a cap, and counts every one.
  task automatic report_mismatch(input string what);
    if (mismatch_count < MAX_PRINTS) begin
      $display("%0t ns: mismatch: %s", $time, what);
    end
    mismatch_count++;
  endtask

  // Availability test of one table entry for the request at hand.
  function automatic bit slot_usable(input int i, input pick_req_t it);
    logic [msp_pkg::STATUS_W-1:0] s;
    s = tbl_status[i];
    if (!s[msp_pkg::ST_PRESENT] || !s[msp_pkg::ST_CAN_SEND]) return 1'b0;
    if (s[msp_pkg::ST_PRE_EST] || s[msp_pkg::ST_FAILED]) return 1'b0;
    if (s[msp_pkg::ST_LOSS] && !(s[msp_pkg::ST_RENO] && s[msp_pkg::ST_UNA_HIGH])) return 1'b0;
    if (!s[msp_pkg::ST_FULLY] && it.has_pkt && s[msp_pkg::ST_SECOND] &&
        tbl_end_seq[i] != it.pkt_seq) begin
      return 1'b0;
    end
    return 1'b1;
  endfunction

  // Applies one transaction to the shadow state; returns 1 when it yields a result.
  function automatic bit predict_pick(input pick_req_t it, output pick_res_t r);
    int                        n_present;
    int                        first_slot;
    int                        backups;
    int                        best;
    int                        low;
    int                        back;
    bit                        has_best;
    bit                        has_low;
    bit                        has_back;
    bit                        lp;
    bit                        queued;
    logic [msp_pkg::RTT_W-1:0] best_rtt;
    logic [msp_pkg::RTT_W-1:0] low_rtt;
    r = '0;
    if (it.op == msp_pkg::OP_UPDATE) begin
      tbl_rtt[it.slot]     = it.rtt;
      tbl_status[it.slot]  = it.status;
      tbl_path[it.slot]    = it.path;
      tbl_end_seq[it.slot] = it.end_seq;
      return 1'b0;
    end

    // A lone present entry is answered directly.
    n_present  = 0;
    first_slot = 0;
    for (int i = 0; i < N_SLOTS; i++) begin
      if (tbl_status[i][msp_pkg::ST_PRESENT]) begin
        if (n_present == 0) first_slot = i;
        n_present++;
      end
    end
    if (n_present == 1) begin
      if (slot_usable(first_slot, it)) begin
        r.found = 1'b1;
        r.slot  = msp_pkg::SLOT_W'(first_slot);
      end
      return 1'b1;
    end

    // A data fin goes to the first available entry on the configured path.
    if (it.rcv_shut && it.has_pkt && it.fin) begin
      for (int i = 0; i < N_SLOTS; i++) begin
        if (tbl_status[i][msp_pkg::ST_PRESENT] && tbl_path[i] == fin_path_cfg &&
            slot_usable(i, it)) begin
          r.found = 1'b1;
          r.slot  = msp_pkg::SLOT_W'(i);
          return 1'b1;
        end
      end
    end

    // Normal scan for the fastest normal and low-priority entries and a backup.
    best_rtt = msp_pkg::RTT_NONE;
    low_rtt  = msp_pkg::RTT_NONE;
    has_best = 1'b0;
    has_low  = 1'b0;
    has_back = 1'b0;
    best     = 0;
    low      = 0;
    back     = 0;
    backups  = 0;
    for (int i = 0; i < N_SLOTS; i++) begin
      if (tbl_status[i][msp_pkg::ST_PRESENT]) begin
        lp = tbl_status[i][msp_pkg::ST_LOW_PRIO];
        if (lp) backups++;
        if ((lp ? (tbl_rtt[i] < low_rtt) : (tbl_rtt[i] < best_rtt)) &&
            slot_usable(i, it)) begin
          queued = it.has_pkt && tbl_path[i] >= 1 && tbl_path[i] <= 32 &&
                   it.pkt_mask[5'(tbl_path[i] - 1)];
          if (queued) begin
            has_back = 1'b1;
            back     = i;
          end else if (lp) begin
            low_rtt = tbl_rtt[i];
            low     = i;
            has_low = 1'b1;
          end else begin
            best_rtt = tbl_rtt[i];
            best     = i;
            has_best = 1'b1;
          end
        end
      end
    end

    r.clear = !(int'(it.estab) == backups && has_low) && !has_best && has_back && it.has_pkt;

    if (deroute_cnt != 0) begin
      if (has_best) begin
        r.found = 1'b1;
        r.slot  = msp_pkg::SLOT_W'(best);
      end
    end else if (has_low) begin
      r.found = 1'b1;
      r.slot  = msp_pkg::SLOT_W'(low);
    end else if (has_back) begin
      r.found = 1'b1;
      r.slot  = msp_pkg::SLOT_W'(back);
    end
    deroute_cnt = (deroute_cnt + 1 >= msp_pkg::DEROUTE_PERIOD_DEF) ? 0 : deroute_cnt + 1;
    return 1'b1;
  endfunction

  function automatic pick_req_t mk_upd(input int slot, input logic [msp_pkg::RTT_W-1:0] rtt,
                                       input logic [msp_pkg::STATUS_W-1:0] status,
                                       input logic [msp_pkg::PATH_W-1:0] path,
                                       input logic [msp_pkg::SEQ_W-1:0] end_seq);
    pick_req_t r;
    r         = '0;
    r.op      = msp_pkg::OP_UPDATE;
    r.slot    = msp_pkg::SLOT_W'(slot);
    r.rtt     = rtt;
    r.status  = status;
    r.path    = path;
    r.end_seq = end_seq;
    return r;
  endfunction

  function automatic pick_req_t mk_sch(input int has_pkt,
                                       input logic [msp_pkg::SEQ_W-1:0] pkt_seq,
                                       input logic [msp_pkg::MASK_W-1:0] pkt_mask,
                                       input int fin, input int rcv_shut, input int estab);
    pick_req_t r;
    r          = '0;
    r.op       = msp_pkg::OP_SCHEDULE;
    r.has_pkt  = 1'(has_pkt);
    r.pkt_seq  = pkt_seq;
    r.pkt_mask = pkt_mask;
    r.fin      = 1'(fin);
    r.rcv_shut = 1'(rcv_shut);
    r.estab    = msp_pkg::ESTAB_W'(estab);
    return r;
  endfunction

  function automatic pick_res_t outcome(input int found, input int slot, input int clear);
    pick_res_t r;
    r.found = 1'(found);
    r.slot  = msp_pkg::SLOT_W'(slot);
    r.clear = 1'(clear);
    return r;
  endfunction

  // Sequence numbers come from a small pool half the time so that they match.
  function automatic logic [msp_pkg::SEQ_W-1:0] pick_seq();
    return ($urandom_range(1) == 0) ? msp_pkg::SEQ_W'($urandom_range(3))
                                    : msp_pkg::SEQ_W'($urandom);
  endfunction

  // Random transaction, biased toward usable entries and matching paths.
  function automatic pick_req_t random_item();
    pick_req_t r;
    int        lp_present;
    r      = '0;
    r.op   = ($urandom_range(99) < 35) ? msp_pkg::OP_UPDATE : msp_pkg::OP_SCHEDULE;
    r.slot = msp_pkg::SLOT_W'($urandom_range(N_SLOTS - 1));
    case ($urandom_range(9))
      0:       r.rtt = '0;
      1:       r.rtt = msp_pkg::RTT_NONE;
      2:       r.rtt = 32'hffff_fffe;
      3, 4, 5: r.rtt = msp_pkg::RTT_W'($urandom_range(15));
      default: r.rtt = msp_pkg::RTT_W'($urandom);
    endcase
    if ($urandom_range(4) == 0) begin
      r.status = msp_pkg::STATUS_W'($urandom_range(1023));
    end else begin
      r.status = F_GOOD;
      if ($urandom_range(4) == 0) r.status[msp_pkg::ST_FULLY] = 1'b0;
      r.status[msp_pkg::ST_SECOND]   = 1'($urandom_range(1));
      r.status[msp_pkg::ST_LOW_PRIO] = ($urandom_range(2) == 0);
      if ($urandom_range(5) == 0) begin
        r.status[msp_pkg::ST_LOSS]     = 1'b1;
        r.status[msp_pkg::ST_RENO]     = ($urandom_range(3) != 0);
        r.status[msp_pkg::ST_UNA_HIGH] = ($urandom_range(3) != 0);
      end
      if ($urandom_range(11) == 0) r.status[msp_pkg::ST_FAILED] = 1'b1;
      if ($urandom_range(11) == 0) r.status[msp_pkg::ST_PRE_EST] = 1'b1;
      if ($urandom_range(15) == 0) r.status[msp_pkg::ST_CAN_SEND] = 1'b0;
    end
    case ($urandom_range(9))
      0:       r.path = 6'd32;
      1:       r.path = msp_pkg::PATH_W'($urandom_range(63));
      2:       r.path = ($urandom_range(1) == 0) ? 6'd0
                                                 : msp_pkg::PATH_W'($urandom_range(33, 63));
      default: r.path = msp_pkg::PATH_W'($urandom_range(1, 8));
    endcase
    r.end_seq = pick_seq();
    r.pkt_seq = pick_seq();
    r.has_pkt = ($urandom_range(99) < 75);
    case ($urandom_range(19))
      0, 1, 2:    r.pkt_mask = '0;
      3, 4, 5:    r.pkt_mask = '1;
      6, 7, 8, 9: r.pkt_mask = msp_pkg::MASK_W'($urandom);
      default:    r.pkt_mask = msp_pkg::MASK_W'($urandom_range(255));
    endcase
    r.fin      = 1'($urandom_range(1));
    r.rcv_shut = 1'($urandom_range(1));
    // The established count often equals the number of low-priority entries.
    if ($urandom_range(9) < 3) begin
      lp_present = 0;
      for (int i = 0; i < N_SLOTS; i++) begin
        if (tbl_status[i][msp_pkg::ST_PRESENT] && tbl_status[i][msp_pkg::ST_LOW_PRIO]) begin
          lp_present++;
        end
      end
      r.estab = msp_pkg::ESTAB_W'(lp_present);
    end else if ($urandom_range(4) == 0) begin
      r.estab = msp_pkg::ESTAB_W'($urandom_range(15));
    end else begin
      r.estab = msp_pkg::ESTAB_W'($urandom_range(8));
    end
    return r;
  endfunction

  // Offers one transaction, waits for acceptance and records what it should yield.
  task automatic push_item(input pick_req_t it, input bit typed, input pick_res_t typed_res);
    pick_res_t pred;
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.operation         <= it.op;
    req_ch.slot              <= it.slot;
    req_ch.rtt_value         <= it.rtt;
    req_ch.status_bits       <= it.status;
    req_ch.path_number       <= it.path;
    req_ch.expected_seq      <= it.end_seq;
    req_ch.has_packet        <= it.has_pkt;
    req_ch.packet_seq        <= it.pkt_seq;
    req_ch.packet_path_mask  <= it.pkt_mask;
    req_ch.is_data_fin       <= it.fin;
    req_ch.receive_shut      <= it.rcv_shut;
    req_ch.established_count <= it.estab;
    req_ch.valid             <= 1'b1;
    do @(posedge clk); while (!req_ch.ready);
    items_sent++;
    if (predict_pick(it, pred)) begin
      expected_picks.push_back(typed ? typed_res : pred);
      schedules_sent++;
    end else begin
      updates_sent++;
    end
  endtask

  // Drops the request, lets every pending result arrive and the block settle.
  task automatic wait_idle();
    req_ch.valid <= 1'b0;
    while (expected_picks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write: setup cycle, then access cycle until pready.
  task automatic write_fin_path(input logic [msp_pkg::PATH_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= msp_pkg::REG_DATA_FIN_PATH;
    pwdata  <= msp_pkg::APB_DATA_W'(val);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    fin_path_cfg = val;
    cfg_writes++;
  endtask

  // Result receiver: random stalls, plus long hold-offs on request.
  always @(posedge clk) begin
    if (rst) begin
      hold_off_left <= 0;
      hold_off_seen <= 0;
      res_ch.ready  <= 1'b0;
    end else if (hold_off_left != 0) begin
      hold_off_left <= hold_off_left - 1;
      res_ch.ready  <= 1'b0;
    end else if (hold_off_seen != hold_off_asked) begin
      hold_off_seen <= hold_off_asked;
      hold_off_left <= HOLD_OFF_CYCLES;
      res_ch.ready  <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Each result transaction is compared with the oldest expectation.
  always @(posedge clk) begin
    pick_res_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (expected_picks.size() == 0) begin
        report_mismatch($sformatf("result found=%0d slot=%0d clear=%0d with nothing expected",
                                  res_ch.found, res_ch.chosen_slot, res_ch.clear_mask));
      end else begin
        want = expected_picks.pop_front();
        results_checked++;
        if (want.found) found_seen++;
        if (want.clear) clear_seen++;
        if (res_ch.found !== want.found) begin
          report_mismatch($sformatf("found %0d, expected %0d", res_ch.found, want.found));
        end
        if (res_ch.chosen_slot !== want.slot) begin
          report_mismatch($sformatf("chosen_slot %0d, expected %0d",
                                    res_ch.chosen_slot, want.slot));
        end
        if (res_ch.clear_mask !== want.clear) begin
          report_mismatch($sformatf("clear_mask %0d, expected %0d",
                                    res_ch.clear_mask, want.clear));
        end
      end
    end
  end

  // Hard limit on the run time.
  initial begin
    #10_000_000;
    $display("[multipath_subflow_picker_unit] ERROR");
    $finish;
  end

  // Main sequence: reset, directed table, then random phases.
  initial begin
    int        goal;
    pick_req_t wipe;
    rst                      = 1'b1;
    psel                     = 1'b0;
    penable                  = 1'b0;
    pwrite                   = 1'b0;
    paddr                    = '0;
    pwdata                   = '0;
    req_ch.valid             = 1'b0;
    req_ch.operation         = msp_pkg::OP_UPDATE;
    req_ch.slot              = '0;
    req_ch.rtt_value         = '0;
    req_ch.status_bits       = '0;
    req_ch.path_number       = '0;
    req_ch.expected_seq      = '0;
    req_ch.has_packet        = 1'b0;
    req_ch.packet_seq        = '0;
    req_ch.packet_path_mask  = '0;
    req_ch.is_data_fin       = 1'b0;
    req_ch.receive_shut      = 1'b0;
    req_ch.established_count = '0;
    send_idle_pct            = 0;
    recv_stall_pct           = 0;
    hold_off_asked           = 0;
    items_sent               = 0;
    updates_sent             = 0;
    schedules_sent           = 0;
    cfg_writes               = 0;
    for (int i = 0; i < N_SLOTS; i++) begin
      tbl_rtt[i]     = '0;
      tbl_status[i]  = '0;
      tbl_path[i]    = '0;
      tbl_end_seq[i] = '0;
    end
    deroute_cnt  = 0;
    fin_path_cfg = msp_pkg::DATA_FIN_PATH_RST;

    // Directed rows; typed results only where they are obvious.
    // Empty table, with and without a data-fin packet.
    stim_rows.push_back('{mk_sch(0, 0, 0, 0, 0, 0), 1'b1, outcome(0, 0, 0)});
    stim_rows.push_back('{mk_sch(1, 0, '1, 1, 1, 8), 1'b1, outcome(0, 0, 0)});
    // A lone entry, usable and then failed.
    stim_rows.push_back('{mk_upd(0, msp_pkg::RTT_NONE, F_GOOD, 1, 0), 1'b0, '0});
    stim_rows.push_back('{mk_sch(1, 0, '1, 0, 0, 0), 1'b1, outcome(1, 0, 0)});
    stim_rows.push_back('{mk_upd(0, 0, F_GOOD | F_FAILED, 1, 0), 1'b0, '0});
    stim_rows.push_back('{mk_sch(0, 0, 0, 0, 0, 0), 1'b1, outcome(0, 0, 0)});
    // All status bits set, and a path outside the mask range.
    stim_rows.push_back('{mk_upd(0, 0, '1, 32, '1), 1'b0, '0});
    stim_rows.push_back('{mk_upd(7, 0, F_GOOD, 63, 0), 1'b0, '0});
    stim_rows.push_back('{mk_sch(1, 0, '1, 0, 0, 0), 1'b0, '0});
    // Low-priority entry, loss without and with recovery, second packet.
    stim_rows.push_back('{mk_upd(3, 5, F_GOOD | F_LOW_PRIO, 2, 0), 1'b0, '0});
    stim_rows.push_back('{mk_upd(0, 3, F_GOOD | F_LOSS, 1, 0), 1'b0, '0});
    stim_rows.push_back('{mk_upd(1, 3, F_GOOD | F_LOSS | F_RENO | F_UNA_HIGH, 4, 0),
                          1'b0, '0});
    stim_rows.push_back('{mk_upd(5, 1, F_PRESENT | F_CAN_SEND | F_SECOND, 3, 32'hdead_beef),
                          1'b0, '0});
    stim_rows.push_back('{mk_sch(1, 32'hdead_beef, 0, 0, 0, 1), 1'b0, '0});
    stim_rows.push_back('{mk_sch(1, 0, 0, 0, 0, 1), 1'b0, '0});
    // Data fin on the reset path.
    stim_rows.push_back('{mk_upd(4, 32'hffff_fffe, F_GOOD, 1, 0), 1'b0, '0});
    stim_rows.push_back('{mk_sch(1, 0, 0, 1, 1, 0), 1'b0, '0});
    // Already queued paths, backups and the mask clear.
    stim_rows.push_back('{mk_sch(1, 0, 32'h0000_000a, 0, 0, 1), 1'b0, '0});
    stim_rows.push_back('{mk_sch(1, 32'hdead_beef, '1, 0, 0, 1), 1'b0, '0});
    // Run the deroute counter through its wrap.
    stim_rows.push_back('{mk_sch(0, 0, 0, 0, 0, 1), 1'b0, '0});
    stim_rows.push_back('{mk_sch(1, 0, 32'h0000_0002, 0, 0, 0), 1'b0, '0});
    stim_rows.push_back('{mk_sch(1, 0, 32'h0000_0008, 1, 0, 1), 1'b0, '0});
    stim_rows.push_back('{mk_sch(1, 0, 0, 0, 1, 15), 1'b0, '0});
    stim_rows.push_back('{mk_sch(1, 0, '1, 0, 0, 1), 1'b0, '0});

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    foreach (stim_rows[k]) push_item(stim_rows[k].req, stim_rows[k].typed, stim_rows[k].res);

    // Random phases, each with its own register setting and idle pattern.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      wait_idle();
      case (ph)
        0:       write_fin_path(6'd32);
        1:       write_fin_path(6'd1);
        default: write_fin_path(($urandom_range(3) == 0)
                                ? msp_pkg::PATH_W'($urandom_range(1, 32))
                                : msp_pkg::PATH_W'($urandom_range(1, 8)));
      endcase
      case (ph % 4)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 56; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 56; end
        default: begin send_idle_pct = 16; recv_stall_pct = 16; end
      endcase
      // Long receiver hold-off while the sender keeps offering.
      if (ph == 0 || ph == 4) hold_off_asked++;
      goal = items_sent + RANDOM_ITEMS / RANDOM_PHASES;
      while (items_sent < goal) begin
        if ($urandom_range(99) < 3) begin
          // Empty the table so that it refills through the lone-entry case.
          for (int s = 0; s < N_SLOTS; s++) begin
            wipe                            = random_item();
            wipe.op                         = msp_pkg::OP_UPDATE;
            wipe.slot                       = msp_pkg::SLOT_W'(s);
            wipe.status[msp_pkg::ST_PRESENT] = 1'b0;
            push_item(wipe, 1'b0, '0);
          end
        end else begin
          push_item(random_item(), 1'b0, '0);
        end
      end
    end

    wait_idle();
    $display("Sent %0d transactions: %0d table updates and %0d schedule requests.",
             items_sent, updates_sent, schedules_sent);
    $display("Checked %0d results (%0d picked an entry, %0d cleared the mask) over %0d settings.",
             results_checked, found_seen, clear_seen, cfg_writes);
    if (mismatch_count == 0) begin
      $display("[multipath_subflow_picker_unit] OK");
    end else begin
      $display("[multipath_subflow_picker_unit] ERROR");
    end
    $finish;
  end

endmodule
